// ===== src/pdc_pkg.sv =====
// Shared widths, codes and word types of the PID controller with deadzone and clamp.
package pdc_pkg;

   localparam int SAMPLE_WIDTH     = 16;
   localparam int TICK_WIDTH       = 16;
   localparam int INTEGRATOR_WIDTH = 48;

   localparam int GAIN_WIDTH      = 16;
   localparam int LIMIT_WIDTH     = 15;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int FRAC_BITS       = 8;

   localparam int ERR_WIDTH  = SAMPLE_WIDTH + 1;
   localparam int IHALF      = INTEGRATOR_WIDTH / 2;
   localparam int IHI_WIDTH  = INTEGRATOR_WIDTH - IHALF;

   localparam int MUL_A_WIDTH = (ERR_WIDTH > GAIN_WIDTH) ? ERR_WIDTH : GAIN_WIDTH;
   localparam int MUL_B_TMP   = (IHI_WIDTH + 1 > TICK_WIDTH + 1) ? IHI_WIDTH + 1
                                                                  : TICK_WIDTH + 1;
   localparam int MUL_B_WIDTH = (MUL_B_TMP > ERR_WIDTH) ? MUL_B_TMP : ERR_WIDTH;
   localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;

   localparam int ISUM_WIDTH = ((PROD_WIDTH > INTEGRATOR_WIDTH) ? PROD_WIDTH
                                                                : INTEGRATOR_WIDTH) + 1;
   localparam int ACC_WIDTH  = 64;
   localparam int Y_WIDTH    = ACC_WIDTH - FRAC_BITS;

   localparam int DIV_CNT_WIDTH = $clog2(SAMPLE_WIDTH);

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_P     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_I     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_D     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUT_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEADZONE   = 3'd4;

   localparam logic signed [GAIN_WIDTH-1:0] GAIN_P_RESET = 16'sd26;

   // item commands
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // multiplier operand selects
   localparam logic [2:0] MUL_ERR_TICKS = 3'd0;
   localparam logic [2:0] MUL_KP_ERR    = 3'd1;
   localparam logic [2:0] MUL_KI_ILO    = 3'd2;
   localparam logic [2:0] MUL_KI_IHI    = 3'd3;
   localparam logic [2:0] MUL_KD_DER    = 3'd4;

   // accumulator operations
   localparam logic [2:0] ACC_HOLD   = 3'd0;
   localparam logic [2:0] ACC_LOAD   = 3'd1;
   localparam logic [2:0] ACC_ADD    = 3'd2;
   localparam logic [2:0] ACC_ADD_HI = 3'd3;
   localparam logic [2:0] ACC_SUB    = 3'd4;

   typedef struct packed {
      logic                           command;
      logic signed [SAMPLE_WIDTH-1:0] setpoint;
      logic signed [SAMPLE_WIDTH-1:0] measurement;
      logic [TICK_WIDTH-1:0]          elapsed_ticks;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] control_out;
      logic                           deadzone_hit;
      logic                           limited;
   } rsp_word_type;

   typedef struct packed {
      logic signed [GAIN_WIDTH-1:0] gain_p;
      logic signed [GAIN_WIDTH-1:0] gain_i;
      logic signed [GAIN_WIDTH-1:0] gain_d;
      logic [LIMIT_WIDTH-1:0]       output_limit;
      logic [LIMIT_WIDTH-1:0]       deadzone_width;
   } cfg_type;

   typedef struct packed {
      logic       load_in;
      logic       check;
      logic [2:0] mul_sel;
      logic [2:0] acc_op;
      logic       integ_add;
      logic       div_start;
      logic       div_step;
      logic       div_fix;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic special;
   } dp_status_type;

endpackage

// ===== src/pdc_csr.sv =====
// Configuration registers: gains, output clamp and deadzone width.
module pdc_csr import pdc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= GAIN_P_RESET;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.output_limit   <= '0;
         cfg_ff.deadzone_width <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_GAIN_P:    cfg_ff.gain_p         <= $signed(csr_data[GAIN_WIDTH-1:0]);
            REG_GAIN_I:    cfg_ff.gain_i         <= $signed(csr_data[GAIN_WIDTH-1:0]);
            REG_GAIN_D:    cfg_ff.gain_d         <= $signed(csr_data[GAIN_WIDTH-1:0]);
            REG_OUT_LIMIT: cfg_ff.output_limit   <= csr_data[LIMIT_WIDTH-1:0];
            REG_DEADZONE:  cfg_ff.deadzone_width <= csr_data[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

endmodule

// ===== src/pdc_ctrl.sv =====
// Sequencer that steps the datapath through one controller update.
module pdc_ctrl import pdc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CHECK   = 4'd1;
   localparam logic [3:0] ST_MUL_IT  = 4'd2;
   localparam logic [3:0] ST_ADD_IT  = 4'd3;
   localparam logic [3:0] ST_DIV     = 4'd4;
   localparam logic [3:0] ST_DIV_FIX = 4'd5;
   localparam logic [3:0] ST_MUL_P   = 4'd6;
   localparam logic [3:0] ST_MUL_ILO = 4'd7;
   localparam logic [3:0] ST_MUL_IHI = 4'd8;
   localparam logic [3:0] ST_MUL_D   = 4'd9;
   localparam logic [3:0] ST_ACC_D   = 4'd10;
   localparam logic [3:0] ST_FINISH  = 4'd11;

   logic [3:0]               state_ff, state_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.special ? ST_FINISH : ST_MUL_IT;
         end
         ST_MUL_IT: begin
            cmd.mul_sel = MUL_ERR_TICKS;
            state_in    = ST_ADD_IT;
         end
         ST_ADD_IT: begin
            cmd.integ_add = 1'b1;
            cmd.div_start = 1'b1;
            cnt_in        = DIV_CNT_WIDTH'(SAMPLE_WIDTH - 1);
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DIV_FIX;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIV_FIX: begin
            cmd.div_fix = 1'b1;
            state_in    = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.mul_sel = MUL_KP_ERR;
            state_in    = ST_MUL_ILO;
         end
         ST_MUL_ILO: begin
            cmd.mul_sel = MUL_KI_ILO;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_MUL_IHI;
         end
         ST_MUL_IHI: begin
            cmd.mul_sel = MUL_KI_IHI;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_sel = MUL_KD_DER;
            cmd.acc_op  = ACC_ADD_HI;
            state_in    = ST_ACC_D;
         end
         ST_ACC_D: begin
            cmd.acc_op = ACC_SUB;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/pdc_dp.sv =====
// Datapath: error, integrator, restoring divider, shared multiplier, accumulator, clamp.
module pdc_dp import pdc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  req_word_type  req_data,
   input  cfg_type       cfg,
   output dp_status_type status,
   output rsp_word_type  rsp_data
);

   req_word_type                       in_ff;
   logic signed [INTEGRATOR_WIDTH-1:0] integ_ff;
   logic signed [SAMPLE_WIDTH-1:0]     prev_ff;
   logic signed [ERR_WIDTH-1:0]        err_ff;
   logic signed [ERR_WIDTH-1:0]        diff_ff;
   logic signed [ERR_WIDTH-1:0]        deriv_ff;
   logic                               special_ff;
   logic                               dzhit_ff;
   logic [SAMPLE_WIDTH-1:0]            num_ff;
   logic [TICK_WIDTH-1:0]              rem_ff;
   logic signed [PROD_WIDTH-1:0]       prod_ff;
   logic signed [ACC_WIDTH-1:0]        acc_ff;
   rsp_word_type                       out_ff;

   logic signed [ERR_WIDTH-1:0]        err;
   logic [ERR_WIDTH-1:0]               err_mag;
   logic signed [ERR_WIDTH-1:0]        diff;
   logic [ERR_WIDTH-1:0]               diff_mag;
   logic                               is_clear;
   logic                               dz;

   logic signed [MUL_A_WIDTH-1:0]      mul_a;
   logic signed [MUL_B_WIDTH-1:0]      mul_b;
   logic signed [PROD_WIDTH-1:0]       prod;

   logic signed [ISUM_WIDTH-1:0]       isum;
   logic [ISUM_WIDTH-INTEGRATOR_WIDTH:0] isum_top;
   logic signed [INTEGRATOR_WIDTH-1:0] integ_in;

   logic [TICK_WIDTH:0]                shifted;
   logic                               div_ge;
   logic [TICK_WIDTH:0]                div_sub;
   logic signed [ERR_WIDTH-1:0]        quo;

   logic signed [ACC_WIDTH-1:0]        prod_ext;
   logic signed [ACC_WIDTH-1:0]        prod_hi;

   logic signed [Y_WIDTH-1:0]          y;
   logic signed [Y_WIDTH-1:0]          lim_pos;
   logic signed [Y_WIDTH-1:0]          lim_neg;
   logic [Y_WIDTH-SAMPLE_WIDTH:0]      y_top;
   rsp_word_type                       out_word;

   // error and deadzone
   assign err      = ERR_WIDTH'(in_ff.setpoint) - ERR_WIDTH'(in_ff.measurement);
   assign err_mag  = err[ERR_WIDTH-1] ? ERR_WIDTH'(-err) : ERR_WIDTH'(err);
   assign diff     = ERR_WIDTH'(in_ff.measurement) - ERR_WIDTH'(prev_ff);
   assign diff_mag = diff_ff[ERR_WIDTH-1] ? ERR_WIDTH'(-diff_ff) : ERR_WIDTH'(diff_ff);
   assign is_clear = (in_ff.command == CMD_CLEAR);
   assign dz       = (cfg.deadzone_width != '0) &&
                     (err_mag < ERR_WIDTH'(cfg.deadzone_width));
   assign status.special = is_clear || dz;

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_ERR_TICKS: begin
            mul_a = MUL_A_WIDTH'(err_ff);
            mul_b = $signed(MUL_B_WIDTH'(in_ff.elapsed_ticks));
         end
         MUL_KP_ERR: begin
            mul_a = MUL_A_WIDTH'(cfg.gain_p);
            mul_b = MUL_B_WIDTH'(err_ff);
         end
         MUL_KI_ILO: begin
            mul_a = MUL_A_WIDTH'(cfg.gain_i);
            mul_b = $signed(MUL_B_WIDTH'(integ_ff[IHALF-1:0]));
         end
         MUL_KI_IHI: begin
            mul_a = MUL_A_WIDTH'(cfg.gain_i);
            mul_b = MUL_B_WIDTH'($signed(integ_ff[INTEGRATOR_WIDTH-1:IHALF]));
         end
         MUL_KD_DER: begin
            mul_a = MUL_A_WIDTH'(cfg.gain_d);
            mul_b = MUL_B_WIDTH'(deriv_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // saturating integrator update
   assign isum     = ISUM_WIDTH'(integ_ff) + ISUM_WIDTH'(prod_ff);
   assign isum_top = isum[ISUM_WIDTH-1:INTEGRATOR_WIDTH-1];
   always_comb begin
      if ((isum_top == '0) || (isum_top == '1)) begin
         integ_in = isum[INTEGRATOR_WIDTH-1:0];
      end else if (isum[ISUM_WIDTH-1]) begin
         integ_in = {1'b1, {(INTEGRATOR_WIDTH-1){1'b0}}};
      end else begin
         integ_in = {1'b0, {(INTEGRATOR_WIDTH-1){1'b1}}};
      end
   end

   // restoring divider step
   assign shifted = {rem_ff, num_ff[SAMPLE_WIDTH-1]};
   assign div_ge  = (shifted >= {1'b0, in_ff.elapsed_ticks});
   assign div_sub = shifted - {1'b0, in_ff.elapsed_ticks};
   assign quo     = $signed({1'b0, num_ff});

   // accumulator operand
   assign prod_ext = ACC_WIDTH'(prod_ff);
   assign prod_hi  = prod_ext <<< IHALF;

   // output shift and clamp
   assign y       = acc_ff[ACC_WIDTH-1:FRAC_BITS];
   assign lim_pos = $signed(Y_WIDTH'(cfg.output_limit));
   assign lim_neg = -lim_pos;
   assign y_top   = y[Y_WIDTH-1:SAMPLE_WIDTH-1];

   always_comb begin
      out_word = '0;
      if (special_ff) begin
         out_word.deadzone_hit = dzhit_ff;
      end else if (cfg.output_limit != '0) begin
         if (y > lim_pos) begin
            out_word.control_out = lim_pos[SAMPLE_WIDTH-1:0];
            out_word.limited     = 1'b1;
         end else if (y < lim_neg) begin
            out_word.control_out = lim_neg[SAMPLE_WIDTH-1:0];
            out_word.limited     = 1'b1;
         end else begin
            out_word.control_out = y[SAMPLE_WIDTH-1:0];
         end
      end else if ((y_top == '0) || (y_top == '1)) begin
         out_word.control_out = y[SAMPLE_WIDTH-1:0];
      end else begin
         out_word.control_out = y[Y_WIDTH-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                             : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
         out_word.limited     = 1'b1;
      end
   end

   assign rsp_data = out_ff;

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         prev_ff  <= '0;
      end else begin
         if (cmd.check) begin
            if (is_clear || dz) begin
               integ_ff <= '0;
            end
            if (!is_clear) begin
               prev_ff <= in_ff.measurement;
            end
         end else if (cmd.integ_add) begin
            integ_ff <= integ_in;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= prod;
      if (cmd.load_in) begin
         in_ff <= req_data;
      end
      if (cmd.check) begin
         special_ff <= is_clear || dz;
         dzhit_ff   <= !is_clear && dz;
         err_ff     <= err;
         diff_ff    <= diff;
      end
      if (cmd.div_start) begin
         num_ff <= diff_mag[SAMPLE_WIDTH-1:0];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[SAMPLE_WIDTH-2:0], div_ge};
         rem_ff <= div_ge ? div_sub[TICK_WIDTH-1:0] : shifted[TICK_WIDTH-1:0];
      end
      if (cmd.div_fix) begin
         if (in_ff.elapsed_ticks == '0) begin
            deriv_ff <= '0;
         end else begin
            deriv_ff <= diff_ff[ERR_WIDTH-1] ? -quo : quo;
         end
      end
      case (cmd.acc_op)
         ACC_LOAD:   acc_ff <= prod_ext;
         ACC_ADD:    acc_ff <= acc_ff + prod_ext;
         ACC_ADD_HI: acc_ff <= acc_ff + prod_hi;
         ACC_SUB:    acc_ff <= acc_ff - prod_ext;
         default:    acc_ff <= acc_ff;
      endcase
      if (cmd.out_load) begin
         out_ff <= out_word;
      end
   end

endmodule

// ===== src/pid_controller_deadzone_clamp.sv =====
// Top level of the PID controller with deadzone, output clamp and derivative on measurement.
//
//   port group  direction  handshake          word
//   req_        in         valid / stall      req_word_type
//   rsp_        out        valid / stall      rsp_word_type
//   csr_        in         valid / ready      index + data
//
// An update word runs the 16-step restoring divider for the derivative and makes five
// passes through the one shared 17x25 multiplier; req_stall holds off the next word
// until the result is loaded. Clear and deadzone words skip from check to finish.
// Reset is synchronous and clears the integrator, the previous measurement and
// the registers to their defaults. A stalled result waits in the output register
// while the next word is accepted and worked on.
module pid_controller_deadzone_clamp import pdc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_word_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_word_type               rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   pdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pdc_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .cfg      (cfg),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ===== src/pdc_checker.sv =====
// Port checks for the PID controller, bound to the top level.
module pdc_checker import pdc_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not held off after accepting a word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.deadzone_hit |-> rsp_data.control_out == '0 &&
                                              !rsp_data.limited)
      else $error("deadzone word with nonzero drive or limit flag");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.limited |-> rsp_data.control_out != '0 &&
                                         !rsp_data.deadzone_hit)
      else $error("limited word with zero drive or deadzone flag");

endmodule

bind pid_controller_deadzone_clamp pdc_checker u_pdc_checker (.*);
